// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define TCH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TCH_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tch_pkg;

	localparam int AXIS_W       = 16;
	localparam int MAGA_W       = 18;
	localparam int CROSS_W      = 34;
	localparam int NY_W         = 50;
	localparam int NMAG_W       = 49;
	localparam int EMAG_W       = 33;
	localparam int EY_LO_W      = 17;
	localparam int SQ_IN_W      = 32;
	localparam int ROOT_W       = 30;
	localparam int REM_W        = 33;
	localparam int SQRT_STEPS   = 30;
	localparam int PL_W         = EY_LO_W + ROOT_W;
	localparam int PH_W         = EMAG_W - EY_LO_W + ROOT_W;
	localparam int X_FRAC       = 14;
	localparam int OP_W         = 64;
	localparam int NORM_TOP     = 29;
	localparam int NORM_STEPS   = 6;
	localparam int CX_W         = 34;
	localparam int Z_W          = 24;
	localparam int PHI_W        = 13;
	localparam int HEAD_W       = 15;
	localparam int CORDIC_STEPS = 20;
	localparam int CFG_ADDR_W   = 3;

	localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		24'd737280, 24'd435242, 24'd229970, 24'd116736, 24'd58595,
		24'd29326,  24'd14667,  24'd7334,   24'd3667,   24'd1833,
		24'd917,    24'd458,    24'd229,    24'd115,    24'd57,
		24'd29,     24'd14,     24'd7,      24'd4,      24'd2
	};

	localparam logic [Z_W-1:0]    QUARTER_FINE = 24'd1474560;
	localparam logic [Z_W-1:0]    ROUND_HALF   = 24'd128;
	localparam logic [HEAD_W-1:0] HALF_TURN    = 15'd11520;
	localparam logic [HEAD_W-1:0] FULL_TURN    = 15'd23040;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	// Side data carried alongside the square root pipeline
	typedef struct packed {
		logic                   zero_e;
		logic                   yneg;
		logic [EMAG_W-1:0]      ey_mag;
		logic signed [NY_W-1:0] ny;
	} tch_side_t;

	// Sign and special-case flags travelling with the angle operands
	typedef struct packed {
		logic degen;
		logic zero_op;
		logic xneg;
		logic yneg;
	} tch_flags_t;

endpackage

`default_nettype wire

// ----- rtl/tilt_compensated_heading.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tilt-compensated compass heading. Each request carries one accelerometer and one
// magnetometer sample (three signed 16-bit axes each); the result is the heading in
// 1/64 degree (0..23039) plus a degenerate flag, set with heading 0 when the east
// vector m' x a has zero length. Hard-iron offsets come from the six min/max registers,
// written only while the pipeline is empty (a user rule the block does not enforce).
// The block takes one request per cycle unless the output stalls. The whole pipeline
// runs the cross products, the bit-per-stage square root of |a|^2, the split multiply,
// operand normalization, 20 CORDIC rotations, rounding and quadrant mapping, and stalls
// together while the output holds an unaccepted result.
module tilt_compensated_heading import tch_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
	input  logic [6*AXIS_W-1:0]   s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// heading_angle, zero fill
	output logic [15:0]           m_axis_tdata,
	// degenerate
	output logic [0:0]            m_axis_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [AXIS_W-1:0]     cfg_wdata
);

	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Calibration registers
	logic signed [AXIS_W-1:0] min_q [3];
	logic signed [AXIS_W-1:0] max_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				min_q[k] <= '0;
				max_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_MIN_X: min_q[0] <= cfg_wdata;
				REG_MIN_Y: min_q[1] <= cfg_wdata;
				REG_MIN_Z: min_q[2] <= cfg_wdata;
				REG_MAX_X: max_q[0] <= cfg_wdata;
				REG_MAX_Y: max_q[1] <= cfg_wdata;
				REG_MAX_Z: max_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage 1: hard-iron correction
	logic signed [AXIS_W-1:0] acc_in [3];
	logic signed [AXIS_W-1:0] mag_in [3];
	logic signed [AXIS_W:0]   osum   [3];
	logic signed [AXIS_W:0]   obias  [3];
	logic signed [AXIS_W:0]   half   [3];
	logic signed [AXIS_W-1:0] a_s1   [3];
	logic signed [MAGA_W-1:0] m_s1   [3];
	logic                     v_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_in[k] = s_axis_tdata[AXIS_W*k +: AXIS_W];
			mag_in[k] = s_axis_tdata[AXIS_W*(k+3) +: AXIS_W];
			osum[k]   = (AXIS_W+1)'(min_q[k]) + (AXIS_W+1)'(max_q[k]);
			// round the half toward zero
			obias[k]  = osum[k] + (AXIS_W+1)'(osum[k][AXIS_W]);
			half[k]   = obias[k] >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= acc_in[k];
				m_s1[k] <= MAGA_W'(mag_in[k]) - MAGA_W'(half[k]);
			end
		end
	end

	// Stage 2: partial products of the cross product and of |a|^2
	logic signed [CROSS_W-1:0] pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;
	logic [SQ_IN_W-1:0]        sq_s2 [3];
	logic signed [AXIS_W-1:0]  ax_s2, az_s2;
	logic                      v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pyz_s2 <= CROSS_W'(m_s1[1] * a_s1[2]);
			pzy_s2 <= CROSS_W'(m_s1[2] * a_s1[1]);
			pzx_s2 <= CROSS_W'(m_s1[2] * a_s1[0]);
			pxz_s2 <= CROSS_W'(m_s1[0] * a_s1[2]);
			pxy_s2 <= CROSS_W'(m_s1[0] * a_s1[1]);
			pyx_s2 <= CROSS_W'(m_s1[1] * a_s1[0]);
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= SQ_IN_W'(a_s1[k] * a_s1[k]);
			end
			ax_s2 <= a_s1[0];
			az_s2 <= a_s1[2];
		end
	end

	// Stage 3: east vector and |a|^2
	logic signed [CROSS_W-1:0] ex_s3, ey_s3, ez_s3;
	logic [SQ_IN_W-1:0]        q_s3;
	logic signed [AXIS_W-1:0]  ax_s3, az_s3;
	logic                      v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s3 <= pyz_s2 - pzy_s2;
			ey_s3 <= pzx_s2 - pxz_s2;
			ez_s3 <= pxy_s2 - pyx_s2;
			q_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			ax_s3 <= ax_s2;
			az_s3 <= az_s2;
		end
	end

	// Stage 4: north products
	logic signed [NY_W-1:0]    pn1_s4, pn2_s4;
	logic signed [CROSS_W-1:0] ey_s4;
	logic [SQ_IN_W-1:0]        q_s4;
	logic                      zero_e_s4;
	logic                      v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pn1_s4    <= NY_W'(az_s3 * ex_s3);
			pn2_s4    <= NY_W'(ax_s3 * ez_s3);
			ey_s4     <= ey_s3;
			q_s4      <= q_s3;
			zero_e_s4 <= (ex_s3 == '0) && (ey_s3 == '0) && (ez_s3 == '0);
		end
	end

	// Stage 5: north y component, east y magnitude
	logic [SQ_IN_W-1:0] q_s5;
	tch_side_t          side_s5;
	logic               v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s5           <= q_s4;
			side_s5.zero_e <= zero_e_s4;
			side_s5.yneg   <= !ey_s4[CROSS_W-1] && (ey_s4 != '0);
			side_s5.ey_mag <= ey_s4[CROSS_W-1] ? EMAG_W'(-ey_s4) : EMAG_W'(ey_s4);
			side_s5.ny     <= pn1_s4 - pn2_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// |a| in Q14
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	tch_side_t         sq_side;

	tch_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_rad    (q_s5),
		.in_side   (side_s5),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Stage 6: split multiply of |Ey| by |a|, magnitude of Ny
	logic [PL_W-1:0]   pl_s6;
	logic [PH_W-1:0]   ph_s6;
	logic [NMAG_W-1:0] nmag_s6;
	tch_flags_t        flags_s6;
	logic              v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s6    <= PL_W'(sq_side.ey_mag[EY_LO_W-1:0] * sq_root);
			ph_s6    <= PH_W'(sq_side.ey_mag[EMAG_W-1:EY_LO_W] * sq_root);
			nmag_s6  <= sq_side.ny[NY_W-1] ? NMAG_W'(-sq_side.ny) : NMAG_W'(sq_side.ny);
			flags_s6.degen   <= sq_side.zero_e;
			flags_s6.zero_op <= (sq_side.ey_mag == '0) && (sq_side.ny == '0);
			flags_s6.xneg    <= !sq_side.ny[NY_W-1] && (sq_side.ny != '0);
			flags_s6.yneg    <= sq_side.yneg;
		end
	end

	// Stage 7: assemble the angle operands
	logic [OP_W-1:0] xmag_s7;
	logic [OP_W-1:0] ymag_s7;
	tch_flags_t      flags_s7;
	logic            v_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			ymag_s7  <= OP_W'(pl_s6) + OP_W'({ph_s6, {EY_LO_W{1'b0}}});
			xmag_s7  <= OP_W'({nmag_s6, {X_FRAC{1'b0}}});
			flags_s7 <= flags_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= sq_valid;
			v_s7 <= v_s6;
		end
	end

	logic [HEAD_W-1:0] heading;
	logic              degen;

	tch_cordic u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (v_s7),
		.in_x        (xmag_s7),
		.in_y        (ymag_s7),
		.in_flags    (flags_s7),
		.out_valid   (m_axis_tvalid),
		.out_heading (heading),
		.out_degen   (degen)
	);

	assign m_axis_tdata = {1'b0, heading};
	assign m_axis_tuser = degen;

endmodule

`default_nettype wire

// ----- rtl/tch_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tch_isqrt import tch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SQ_IN_W-1:0] in_rad,
	input  tch_side_t          in_side,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  out_root,
	output tch_side_t          out_side
);

	// radicand is in_rad scaled by 2^PAD, so the low pairs are zero
	localparam int PAD = 2 * SQRT_STEPS - SQ_IN_W;

	logic                vld_s  [SQRT_STEPS+1];
	logic [REM_W-1:0]    rem_s  [SQRT_STEPS+1];
	logic [ROOT_W-1:0]   root_s [SQRT_STEPS+1];
	logic [SQ_IN_W-1:0]  rad_s  [SQRT_STEPS+1];
	tch_side_t           side_s [SQRT_STEPS+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam int HI = 2 * SQRT_STEPS - 1 - 2 * j;
		logic [1:0]       pair;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (HI - 1 >= PAD) begin : g_data
			assign pair = rad_s[j][HI-PAD -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign cur   = {rem_s[j][REM_W-3:0], pair};
		assign trial = REM_W'({root_s[j], 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? cur - trial : cur;
				root_s[j+1] <= {root_s[j][ROOT_W-2:0], ge};
				rad_s[j+1]  <= rad_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign out_root  = root_s[SQRT_STEPS];
	assign out_side  = side_s[SQRT_STEPS];

endmodule

`default_nettype wire

// ----- rtl/tch_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tch_cordic import tch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [OP_W-1:0]   in_x,
	input  logic [OP_W-1:0]   in_y,
	input  tch_flags_t        in_flags,
	output logic              out_valid,
	output logic [HEAD_W-1:0] out_heading,
	output logic              out_degen
);

	// Normalize: bring the larger magnitude into [2^29, 2^30), one shift size a stage
	logic [OP_W-1:0] nx_s [NORM_STEPS+1];
	logic [OP_W-1:0] ny_s [NORM_STEPS+1];
	tch_flags_t      nf_s [NORM_STEPS+1];
	logic            nv_s [NORM_STEPS+1];

	assign nx_s[0] = in_x;
	assign ny_s[0] = in_y;
	assign nf_s[0] = in_flags;
	assign nv_s[0] = in_valid;

	for (genvar n = 0; n < NORM_STEPS; n++) begin : g_norm
		localparam int K = 1 << (NORM_STEPS - 1 - n);
		logic [OP_W-1:0] orv;
		logic            rsh;
		logic            lsh;

		assign orv = nx_s[n] | ny_s[n];
		assign rsh = |orv[OP_W-1:NORM_TOP+K];
		if (NORM_TOP + 1 > K) begin : g_left
			assign lsh = ~|orv[OP_W-1:NORM_TOP+1-K];
		end else begin : g_noleft
			assign lsh = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nv_s[n+1] <= 1'b0;
			end else if (en) begin
				nv_s[n+1] <= nv_s[n];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nf_s[n+1] <= nf_s[n];
				if (rsh) begin
					nx_s[n+1] <= nx_s[n] >> K;
					ny_s[n+1] <= ny_s[n] >> K;
				end else if (lsh) begin
					nx_s[n+1] <= nx_s[n] << K;
					ny_s[n+1] <= ny_s[n] << K;
				end else begin
					nx_s[n+1] <= nx_s[n];
					ny_s[n+1] <= ny_s[n];
				end
			end
		end
	end

	// Vectoring rotations, one per stage
	logic signed [CX_W-1:0] cx_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] cy_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  cz_s [CORDIC_STEPS+1];
	tch_flags_t             cf_s [CORDIC_STEPS+1];
	logic                   cv_s [CORDIC_STEPS+1];

	assign cx_s[0] = CX_W'(nx_s[NORM_STEPS][NORM_TOP:0]);
	assign cy_s[0] = CX_W'(ny_s[NORM_STEPS][NORM_TOP:0]);
	assign cz_s[0] = '0;
	assign cf_s[0] = nf_s[NORM_STEPS];
	assign cv_s[0] = nv_s[NORM_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic [CX_W-1:0] LOW_MASK = CX_W'((64'd1 << i) - 64'd1);
		logic                   ypos;
		logic signed [CX_W-1:0] sy;
		logic signed [CX_W-1:0] sx;
		logic signed [CX_W-1:0] dx;

		assign ypos = !cy_s[i][CX_W-1];
		assign sy   = cy_s[i] >>> i;
		assign sx   = cx_s[i] >>> i;
		// truncate a negative residual toward zero
		assign dx   = ypos ? sy : sy + CX_W'((cy_s[i] & LOW_MASK) != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cf_s[i+1] <= cf_s[i];
				if (ypos) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - sx;
					cz_s[i+1] <= cz_s[i] + signed'(ATAN_TAB[i]);
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + sx;
					cz_s[i+1] <= cz_s[i] - signed'(ATAN_TAB[i]);
				end
			end
		end
	end

	// Clamp and round to 1/64 degree
	logic signed [Z_W-1:0] zf;
	logic [Z_W-1:0]        zc;
	logic [Z_W-1:0]        zr;
	logic [PHI_W-1:0]      phi_s27;
	tch_flags_t            flags_s27;
	logic                  vld_s27;

	always_comb begin
		zf = cz_s[CORDIC_STEPS];
		if (zf < 0) begin
			zc = '0;
		end else if (zf > signed'(QUARTER_FINE)) begin
			zc = QUARTER_FINE;
		end else begin
			zc = zf;
		end
		zr = zc + ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27 <= 1'b0;
		end else if (en) begin
			vld_s27 <= cv_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s27   <= zr[8 +: PHI_W];
			flags_s27 <= cf_s[CORDIC_STEPS];
		end
	end

	// Map to the quadrant and wrap
	logic [HEAD_W-1:0] ext;
	logic [HEAD_W-1:0] ang;
	logic [HEAD_W-1:0] angw;
	logic [HEAD_W-1:0] head_s28;
	logic              degen_s28;
	logic              vld_s28;

	always_comb begin
		ext = HEAD_W'(phi_s27);
		unique case ({flags_s27.xneg, flags_s27.yneg})
			2'b00: ang = ext;
			2'b10: ang = HALF_TURN - ext;
			2'b11: ang = HALF_TURN + ext;
			2'b01: ang = FULL_TURN - ext;
		endcase
		angw = (ang >= FULL_TURN) ? ang - FULL_TURN : ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s28 <= 1'b0;
		end else if (en) begin
			vld_s28 <= vld_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s28 <= flags_s27.degen;
			head_s28  <= (flags_s27.degen || flags_s27.zero_op) ? '0 : angw;
		end
	end

	assign out_valid   = vld_s28;
	assign out_heading = head_s28;
	assign out_degen   = degen_s28;

endmodule

`default_nettype wire

// ----- rtl/tch_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tch_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire [0:0]  m_axis_tuser
);

	`TCH_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |=> !m_axis_tvalid, "result during reset")

	`TCH_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	`TCH_ASSERT(a_range, m_axis_tvalid |-> m_axis_tdata < 16'd23040, "heading out of range")

	`TCH_ASSERT(a_degen_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0, "degenerate result with nonzero heading")

	`TCH_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "empty output blocks input")

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (.*);

`default_nettype wire

// ----- verif/tilt_compensated_heading_test.sv -----
`timescale 1ns / 1ps

module tilt_compensated_heading_test;
	import tch_pkg::*;

	localparam int LATENCY = 65;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM = 1500;

	typedef struct {
		logic [14:0] heading;
		logic        degen;
	} heading_t;

	typedef logic [6*AXIS_W-1:0] sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [6*AXIS_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [AXIS_W-1:0] cfg_wdata = '0;

	tilt_compensated_heading u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic signed [15:0] cal_reg [6];
	sample_t   pending_samples [$];
	heading_t  expected_headings [$];
	int        error_count = 0;
	int        result_count = 0;
	int        degen_count = 0;
	int        send_idle_pct = 35;
	int        recv_idle_pct = 45;
	int        hold_cycles = 0;
	longint    cycle_count = 0;
	logic      in_taken = 1'b0;

	// Exact integer square root of a 64-bit value.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	function automatic longint trunc_shift(longint v, int s);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = m >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic int quadrant_angle(longint unsigned ax, longint unsigned ay);
		longint x, y, z, dx, dy;
		z = 0;
		while ((ax > ay ? ax : ay) >= (64'd1 << 30)) begin
			ax >>= 1;
			ay >>= 1;
		end
		while ((ax > ay ? ax : ay) < (64'd1 << 29)) begin
			ax <<= 1;
			ay <<= 1;
		end
		x = ax;
		y = ay;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = trunc_shift(y, i);
			dy = trunc_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(QUARTER_FINE)) z = QUARTER_FINE;
		return int'((z + 128) >> 8);
	endfunction

	function automatic heading_t predict_heading(sample_t d);
		heading_t r;
		longint ax, ay, az, mx, my, mz, ex, ey, ez, ny, ang;
		longint unsigned s, ymag, xmag;
		logic yneg, xneg;
		int phi;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		az = longint'($signed(d[47:32]));
		mx = longint'($signed(d[63:48])) - (longint'(cal_reg[REG_MIN_X]) + cal_reg[REG_MAX_X]) / 2;
		my = longint'($signed(d[79:64])) - (longint'(cal_reg[REG_MIN_Y]) + cal_reg[REG_MAX_Y]) / 2;
		mz = longint'($signed(d[95:80])) - (longint'(cal_reg[REG_MIN_Z]) + cal_reg[REG_MAX_Z]) / 2;
		ex = my * az - mz * ay;
		ey = mz * ax - mx * az;
		ez = mx * ay - my * ax;
		r.heading = '0;
		r.degen = 1'b0;
		if (ex == 0 && ey == 0 && ez == 0) begin
			r.degen = 1'b1;
			return r;
		end
		ny = az * ex - ax * ez;
		s = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 28);
		ymag = ((ey < 0) ? -ey : ey) * s;
		xmag = ((ny < 0) ? -ny : ny) << 14;
		yneg = (ey > 0) && (ymag != 0);
		xneg = (ny > 0) && (xmag != 0);
		if (ymag == 0 && xmag == 0) return r;
		phi = quadrant_angle(xmag, ymag);
		if (!xneg && !yneg) ang = phi;
		else if (xneg && !yneg) ang = 11520 - phi;
		else if (xneg && yneg) ang = 11520 + phi;
		else ang = 23040 - phi;
		if (ang >= 23040) ang -= 23040;
		r.heading = ang[14:0];
		return r;
	endfunction

	function automatic sample_t pack_sample(int a0, int a1, int a2, int m0, int m1, int m2);
		logic [15:0] v [6];
		v[0] = 16'(a0); v[1] = 16'(a1); v[2] = 16'(a2);
		v[3] = 16'(m0); v[4] = 16'(m1); v[5] = 16'(m2);
		return {v[5], v[4], v[3], v[2], v[1], v[0]};
	endfunction

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	task automatic write_cal(cfg_reg_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		cal_reg[idx] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || expected_headings.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_headings.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Record the input handshake at the rising edge where it actually happens.
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// Driver: the prediction is taken at acceptance so it sees the live calibration.
	always @(negedge clk) begin
		logic offer;
		if (arst_n) begin
			if (in_taken) begin
				expected_headings.push_back(predict_heading(s_axis_tdata));
				void'(pending_samples.pop_front());
			end
			offer = (pending_samples.size() != 0) &&
				($urandom_range(0, 99) >= send_idle_pct);
			if (s_axis_tvalid && !in_taken)
				offer = 1'b1;
			s_axis_tvalid <= offer;
			if (offer) s_axis_tdata <= pending_samples[0];
		end
	end

	// Receiver stall pattern: either a long hold-off or random gaps.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		heading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (expected_headings.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, -1);
			end else begin
				want = expected_headings.pop_front();
				if (m_axis_tdata != {1'b0, want.heading})
					report_mismatch("heading", m_axis_tdata, want.heading);
				if (m_axis_tuser[0] != want.degen)
					report_mismatch("degenerate", m_axis_tuser[0], want.degen);
				if (want.degen) degen_count++;
			end
		end
	end

	task automatic random_phase(int count);
		int a[3];
		int m[3];
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 3; k++) begin
				a[k] = int'($signed(rand_axis()));
				m[k] = int'($signed(rand_axis()));
			end
			case ($urandom_range(0, 19))
				// parallel a and m' gives a zero east vector
				0: pending_samples.push_back(pack_sample(a[0], a[1], a[2],
					a[0] + (cal_reg[REG_MIN_X] + cal_reg[REG_MAX_X]) / 2,
					a[1] + (cal_reg[REG_MIN_Y] + cal_reg[REG_MAX_Y]) / 2,
					a[2] + (cal_reg[REG_MIN_Z] + cal_reg[REG_MAX_Z]) / 2));
				1: pending_samples.push_back(pack_sample(0, 0, 0, m[0], m[1], m[2]));
				default: pending_samples.push_back(pack_sample(a[0], a[1], a[2],
					m[0], m[1], m[2]));
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < 6; i++) cal_reg[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: level, tilted, extremes, degenerate and zero-operand cases
		pending_samples.push_back(pack_sample(0, 0, 16384, 1000, 0, 0));
		pending_samples.push_back(pack_sample(0, 0, 16384, -1000, 0, 0));
		pending_samples.push_back(pack_sample(0, 0, 16384, 0, 1000, 0));
		pending_samples.push_back(pack_sample(0, 0, 16384, 0, -1000, 0));
		pending_samples.push_back(pack_sample(0, 0, 16384, 700, 700, 50));
		pending_samples.push_back(pack_sample(0, 0, 16384, -700, -700, 50));
		pending_samples.push_back(pack_sample(0, 0, 16384, 1000, -1, 0));
		pending_samples.push_back(pack_sample(0, 0, 16384, 1000, 1, 0));
		pending_samples.push_back(pack_sample(0, 0, 0, 100, 200, 300));
		pending_samples.push_back(pack_sample(5, 6, 7, 10, 12, 14));
		pending_samples.push_back(pack_sample(0, 0, 0, 0, 0, 0));
		pending_samples.push_back(pack_sample(0, 1000, 0, 0, 500, 0));
		pending_samples.push_back(pack_sample(1000, 0, 0, 0, 0, 800));
		pending_samples.push_back(pack_sample(-32768, -32768, -32768, 32767, 32767, 32767));
		pending_samples.push_back(pack_sample(32767, 32767, 32767, -32768, -32768, -32768));
		pending_samples.push_back(pack_sample(-32768, 32767, -32768, 32767, -32768, 1));
		pending_samples.push_back(pack_sample(32767, -32768, 0, -32768, 32767, -1));
		pending_samples.push_back(pack_sample(1, -1, 1, -1, 1, -1));
		drain();
		repeat (LATENCY) @(negedge clk);

		// extremes, min above max
		write_cal(REG_MIN_X, 16'h8000);
		write_cal(REG_MIN_Y, 16'h7fff);
		write_cal(REG_MIN_Z, 16'h8000);
		write_cal(REG_MAX_X, 16'h8000);
		write_cal(REG_MAX_Y, 16'h8001);
		write_cal(REG_MAX_Z, 16'h7fff);
		random_phase(N_RANDOM / 3);
		// long receiver hold-off so the pipeline fills and backs up
		@(negedge clk);
		hold_cycles <= 300;
		drain();
		repeat (LATENCY) @(negedge clk);

		send_idle_pct = 45;
		recv_idle_pct = 35;
		write_cal(REG_MIN_X, 16'd3);
		write_cal(REG_MIN_Y, -16'd201);
		write_cal(REG_MIN_Z, 16'h7fff);
		write_cal(REG_MAX_X, 16'h7fff);
		write_cal(REG_MAX_Y, 16'd150);
		write_cal(REG_MAX_Z, 16'h7fff);
		random_phase(N_RANDOM / 3);
		drain();
		repeat (LATENCY) @(negedge clk);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 6; i++) write_cal(cfg_reg_t'(i), 16'($urandom_range(0, 4000)) - 16'd2000);
		random_phase(N_RANDOM / 3);
		drain();
		repeat (LATENCY + 20) @(negedge clk);

		$display("checked %0d headings, %0d degenerate, over three calibration settings",
			result_count, degen_count);
		$display("stall patterns: sender-heavy, receiver-heavy, none, plus a long output hold");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
